// ===== src/threshold_calibration_search_core_assert.svh =====
// ----------------------------------------------------------------------------
// threshold calibration search assertion macros
// shared concurrent assertion forms, synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_CALIBRATION_SEARCH_CORE_ASSERT_SVH
`define THRESHOLD_CALIBRATION_SEARCH_CORE_ASSERT_SVH

// same-cycle implication
`define TCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tcs same-cycle check failed");

// next-cycle implication
`define TCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tcs next-cycle check failed");

`endif

// ===== src/tcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tcs_pkg
// types and constants of the threshold calibration search core
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int ChanW    = 7;
  localparam int VrefW    = 10;
  localparam int EppW     = 16;
  localparam int IterW    = 6;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  localparam logic [EppW-1:0]  EPP_RST   = 16'd100;
  localparam logic [IterW-1:0] MAXIT_RST = 6'd40;
  localparam logic [VrefW-1:0] VUP_RST   = 10'd600;
  localparam logic [VrefW-1:0] VUP_MIN   = 10'd2;

  localparam logic [1:0] REG_EPP   = 2'd0;
  localparam logic [1:0] REG_MAXIT = 2'd1;
  localparam logic [1:0] REG_VUP   = 2'd2;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_EVENT = 1'b1;

  typedef enum logic [1:0] {
    KIND_MEAS = 2'd0,
    KIND_SET  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ChanW-1:0]  chan;
    logic              link;
    logic [VrefW-1:0]  vref;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [EppW-1:0]  epp;
    logic [IterW-1:0] maxit;
    logic [VrefW-1:0] vup;
  } cfg_t;

endpackage

// ===== src/threshold_calibration_search_core.sv =====
// ----------------------------------------------------------------------------
// threshold_calibration_search_core
// per-channel threshold calibration sequencer with bisection and linear scan
// ----------------------------------------------------------------------------
// a request's first result passes the input register, then the result queue
// throughput: one request per cycle while the queue has space; decision is
//   a single registered pass; a request causing two results yields two beats,
//   the result queue of four entries stalls input once it holds more than two
// reset: synchronous active low, scan idle, thresholds cleared, registers at
//   their defaults, result queue empty
// ----------------------------------------------------------------------------
module threshold_calibration_search_core import tcs_pkg::*; #(
  parameter int NUM_CHANNELS      = 72,
  parameter int CHANNELS_PER_LINK = 36
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [0] triggered
  input  logic [0:0]          in_tuser,   // [0] func
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // [6:0] chan, [7] link, [17:8] vref
  output logic [1:0]          out_tuser,  // [1:0] kind
  output logic                out_tlast,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  cfg_t  cfg;
  push_t push;
  logic  space_ok;
  res_t  out_res;

  tcs_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  tcs_seq #(
    .NUM_CHANNELS      (NUM_CHANNELS),
    .CHANNELS_PER_LINK (CHANNELS_PER_LINK)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .in_vld_i   (in_tvalid),
    .in_rdy_o   (in_tready),
    .in_func_i  (in_tuser[0]),
    .in_trig_i  (in_tdata[0]),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  tcs_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .space_ok_o (space_ok),
    .out_vld_o  (out_tvalid),
    .out_rdy_i  (out_tready),
    .out_res_o  (out_res)
  );

  assign out_tdata = {6'b0, out_res.vref, out_res.link, out_res.chan};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

// ===== src/tcs_cfg.sv =====
// ----------------------------------------------------------------------------
// tcs_cfg
// configuration register bank behind the register bus
// ----------------------------------------------------------------------------
module tcs_cfg import tcs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready,
  output cfg_t                cfg_o
);

  logic [EppW-1:0]  epp_r;
  logic [IterW-1:0] maxit_r;
  logic [VrefW-1:0] vup_r;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epp_r   <= EPP_RST;
      maxit_r <= MAXIT_RST;
      vup_r   <= VUP_RST;
    end else if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_EPP:   epp_r   <= cfg_pwdata[EppW-1:0];
        REG_MAXIT: maxit_r <= cfg_pwdata[IterW-1:0];
        REG_VUP:   vup_r   <= cfg_pwdata[VrefW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_EPP:   cfg_prdata = {{(CfgDataW-EppW){1'b0}}, epp_r};
      REG_MAXIT: cfg_prdata = {{(CfgDataW-IterW){1'b0}}, maxit_r};
      REG_VUP:   cfg_prdata = {{(CfgDataW-VrefW){1'b0}}, vup_r};
      default:   cfg_prdata = '0;
    endcase
  end

  assign cfg_o = '{epp: epp_r, maxit: maxit_r, vup: vup_r};

endmodule

// ===== src/tcs_seq.sv =====
// ----------------------------------------------------------------------------
// tcs_seq
// input register, scan state and single-pass efficiency decision
// ----------------------------------------------------------------------------
`include "threshold_calibration_search_core_assert.svh"

module tcs_seq import tcs_pkg::*; #(
  parameter int NUM_CHANNELS      = 72,
  parameter int CHANNELS_PER_LINK = 36
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg_i,
  input  logic  in_vld_i,
  output logic  in_rdy_o,
  input  logic  in_func_i,
  input  logic  in_trig_i,
  input  logic  space_ok_i,
  output push_t push_o
);

  localparam int SubW = (CHANNELS_PER_LINK > 1) ? $clog2(CHANNELS_PER_LINK) : 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_GLOBAL,
    PH_CHECK,
    PH_LOCAL
  } phase_t;

  logic              stage_vld_r, stage_vld_nxt;
  logic              stage_func_r, stage_func_nxt;
  logic              stage_trig_r, stage_trig_nxt;
  phase_t            phase_r, phase_nxt;
  logic [ChanW-1:0]  ch_r, ch_nxt;
  logic [SubW-1:0]   sub_r, sub_nxt;
  logic              lk_r, lk_nxt;
  logic [VrefW-1:0]  thr_r [2];
  logic [VrefW-1:0]  thr_nxt [2];
  logic [1:0]        thr_vld_r, thr_vld_nxt;
  logic [VrefW-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, tv_r, tv_nxt, sv_r, sv_nxt;
  logic [IterW-1:0]  iter_r, iter_nxt;
  logic [EppW-1:0]   ec_r, ec_nxt, hc_r, hc_nxt;

  logic              fire;
  logic [VrefW-1:0]  up;
  logic [EppW-1:0]   need;
  logic [EppW-1:0]   ec_inc, hc_inc;
  logic [EppW+2:0]   h5, ne4, ne1;
  logic [EppW:0]     h2, ne2;
  logic              eff_window, above, below;

  assign fire     = stage_vld_r & space_ok_i;
  assign in_rdy_o = ~stage_vld_r | space_ok_i;

  assign up     = (cfg_i.vup < VUP_MIN) ? VUP_MIN : cfg_i.vup;
  assign need   = (cfg_i.epp == '0) ? EppW'(1) : cfg_i.epp;
  assign ec_inc = (ec_r != '1) ? ec_r + EppW'(1) : ec_r;
  assign hc_inc = (stage_trig_r && (hc_r < ec_inc)) ? hc_r + EppW'(1) : hc_r;

  // efficiency windows as exact rational compares
  assign h5         = {1'b0, hc_inc, 2'b00} + {3'b000, hc_inc};
  assign ne4        = {1'b0, ec_inc, 2'b00};
  assign ne1        = {3'b000, ec_inc};
  assign h2         = {hc_inc, 1'b0};
  assign ne2        = {1'b0, ec_inc};
  assign eff_window = (h5 > ne1) && (h5 < ne4);
  assign above      = h2 > ne2;
  assign below      = h2 < ne2;

  always_comb begin
    logic             do_fin, do_adv, do_req, do_err;
    logic [VrefW-1:0] fin_v;
    logic [IterW-1:0] iter_sat;
    logic [VrefW-1:0] span, lo_s, hi_s;
    logic [VrefW:0]   mid, nx;
    logic [ChanW:0]   ch_plus;
    logic             nlk;
    res_t             res_b;

    stage_vld_nxt  = stage_vld_r;
    stage_func_nxt = stage_func_r;
    stage_trig_nxt = stage_trig_r;
    phase_nxt      = phase_r;
    ch_nxt         = ch_r;
    sub_nxt        = sub_r;
    lk_nxt         = lk_r;
    thr_nxt        = thr_r;
    thr_vld_nxt    = thr_vld_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    tv_nxt         = tv_r;
    sv_nxt         = sv_r;
    iter_nxt       = iter_r;
    ec_nxt         = ec_r;
    hc_nxt         = hc_r;
    push_o         = '0;
    do_fin         = 1'b0;
    do_adv         = 1'b0;
    do_req         = 1'b0;
    do_err         = 1'b0;
    fin_v          = tv_r;
    iter_sat       = iter_r;
    span           = '0;
    lo_s           = lo_r;
    hi_s           = hi_r;
    mid            = '0;
    nx             = {1'b0, tv_r} + (VrefW+1)'(1);
    ch_plus        = {1'b0, ch_r} + (ChanW+1)'(1);
    nlk            = lk_r;
    res_b          = '0;

    if (in_vld_i && in_rdy_o) begin
      stage_vld_nxt  = 1'b1;
      stage_func_nxt = in_func_i;
      stage_trig_nxt = in_trig_i;
    end else if (fire) begin
      stage_vld_nxt = 1'b0;
    end

    if (fire) begin
      if (stage_func_r == FUNC_START) begin
        thr_nxt[0]  = '0;
        thr_nxt[1]  = '0;
        thr_vld_nxt = '0;
        ch_nxt      = '0;
        sub_nxt     = '0;
        lk_nxt      = 1'b0;
        phase_nxt   = PH_GLOBAL;
        lo_nxt      = '0;
        hi_nxt      = up;
        iter_nxt    = '0;
        tv_nxt      = up >> 1;
        ec_nxt      = '0;
        hc_nxt      = '0;
        push_o.n    = 2'd1;
        push_o.r0   = '{kind: KIND_MEAS, chan: '0, link: 1'b0, vref: up >> 1, last: 1'b1};
      end else if (phase_r != PH_IDLE) begin
        ec_nxt = ec_inc;
        hc_nxt = hc_inc;
        if (ec_inc >= need) begin
          case (phase_r)
            PH_GLOBAL: begin
              if (eff_window) begin
                do_fin = 1'b1;
              end else if ((tv_r == '0) || (tv_r == up)) begin
                do_err = 1'b1;
              end else begin
                iter_sat = (iter_r != '1) ? iter_r + IterW'(1) : iter_r;
                iter_nxt = iter_sat;
                span     = (hi_r > lo_r) ? hi_r - lo_r : lo_r - hi_r;
                if (iter_sat > cfg_i.maxit) begin
                  do_fin = 1'b1;
                end else if (span <= VrefW'(1)) begin
                  do_fin = 1'b1;
                end else begin
                  if (above) lo_s = tv_r;
                  else       hi_s = tv_r;
                  mid    = {1'b0, lo_s} + {1'b0, hi_s};
                  lo_nxt = lo_s;
                  hi_nxt = hi_s;
                  tv_nxt = mid[VrefW:1];
                  do_req = 1'b1;
                end
              end
            end
            PH_CHECK: begin
              if (below) begin
                do_adv = 1'b1;
              end else begin
                sv_nxt = tv_r;
                if (tv_r > up) begin
                  do_fin = 1'b1;
                end else begin
                  phase_nxt = PH_LOCAL;
                  do_req    = 1'b1;
                end
              end
            end
            PH_LOCAL: begin
              if (below) begin
                do_fin = 1'b1;
              end else if (nx > {1'b0, up}) begin
                do_fin = 1'b1;
                fin_v  = sv_r;
              end else begin
                tv_nxt = nx[VrefW-1:0];
                do_req = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
    end

    if (do_fin) begin
      thr_nxt[lk_r]     = fin_v;
      thr_vld_nxt[lk_r] = 1'b1;
      do_adv            = 1'b1;
    end

    if (do_adv) begin
      if (ch_plus >= (ChanW+1)'(NUM_CHANNELS)) begin
        phase_nxt = PH_IDLE;
        res_b     = '{kind: KIND_DONE, chan: '0, link: 1'b0, vref: '0, last: 1'b1};
      end else begin
        ch_nxt = ch_plus[ChanW-1:0];
        if (sub_r == SubW'(CHANNELS_PER_LINK - 1)) begin
          sub_nxt = '0;
          nlk     = ~lk_r;
        end else begin
          sub_nxt = sub_r + SubW'(1);
        end
        lk_nxt = nlk;
        if (thr_vld_nxt[nlk]) begin
          phase_nxt = PH_CHECK;
          tv_nxt    = thr_nxt[nlk];
        end else begin
          phase_nxt = PH_GLOBAL;
          lo_nxt    = '0;
          hi_nxt    = up;
          iter_nxt  = '0;
          tv_nxt    = up >> 1;
        end
        ec_nxt = '0;
        hc_nxt = '0;
        res_b  = '{kind: KIND_MEAS, chan: ch_plus[ChanW-1:0], link: nlk, vref: tv_nxt,
                   last: 1'b1};
      end
    end

    if (do_req) begin
      ec_nxt = '0;
      hc_nxt = '0;
      res_b  = '{kind: KIND_MEAS, chan: ch_r, link: lk_r, vref: tv_nxt, last: 1'b1};
    end

    if (do_err) begin
      phase_nxt = PH_IDLE;
      res_b     = '{kind: KIND_ERR, chan: ch_r, link: 1'b0, vref: '0, last: 1'b1};
    end

    if (do_fin) begin
      push_o.n  = 2'd2;
      push_o.r0 = '{kind: KIND_SET, chan: ch_r, link: lk_r, vref: fin_v, last: 1'b0};
      push_o.r1 = res_b;
    end else if (do_adv || do_req || do_err) begin
      push_o.n  = 2'd1;
      push_o.r0 = res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r  <= 1'b0;
      stage_func_r <= FUNC_START;
      stage_trig_r <= 1'b0;
      phase_r      <= PH_IDLE;
      ch_r         <= '0;
      sub_r        <= '0;
      lk_r         <= 1'b0;
      thr_r[0]     <= '0;
      thr_r[1]     <= '0;
      thr_vld_r    <= '0;
      lo_r         <= '0;
      hi_r         <= '0;
      tv_r         <= '0;
      sv_r         <= '0;
      iter_r       <= '0;
      ec_r         <= '0;
      hc_r         <= '0;
    end else begin
      stage_vld_r  <= stage_vld_nxt;
      stage_func_r <= stage_func_nxt;
      stage_trig_r <= stage_trig_nxt;
      phase_r      <= phase_nxt;
      ch_r         <= ch_nxt;
      sub_r        <= sub_nxt;
      lk_r         <= lk_nxt;
      thr_r        <= thr_nxt;
      thr_vld_r    <= thr_vld_nxt;
      lo_r         <= lo_nxt;
      hi_r         <= hi_nxt;
      tv_r         <= tv_nxt;
      sv_r         <= sv_nxt;
      iter_r       <= iter_nxt;
      ec_r         <= ec_nxt;
      hc_r         <= hc_nxt;
    end
  end

  `TCS_ASSERT_IMP(a_start_one_req, clk, rst_n, fire && (stage_func_r == FUNC_START), (push_o.n == 2'd1) && (push_o.r0.kind == KIND_MEAS))
  `TCS_ASSERT_IMP(a_idle_event_silent, clk, rst_n, fire && (stage_func_r == FUNC_EVENT) && (phase_r == PH_IDLE), push_o.n == 2'd0)
  `TCS_ASSERT_IMP(a_pair_opens_with_set, clk, rst_n, push_o.n == 2'd2, (push_o.r0.kind == KIND_SET) && (push_o.r1.kind != KIND_SET))
  `TCS_ASSERT_NXT(a_set_marks_valid, clk, rst_n, fire && (push_o.n == 2'd2), thr_vld_r != 2'b00)

endmodule

// ===== src/tcs_outq.sv =====
// ----------------------------------------------------------------------------
// tcs_outq
// four-entry result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module tcs_outq import tcs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push_i,
  output logic  space_ok_o,
  output logic  out_vld_o,
  input  logic  out_rdy_i,
  output res_t  out_res_o
);

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);

  res_t              mem [QDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]     count_r, count_nxt;
  logic              pop;

  assign space_ok_o = count_r <= (PtrW+1)'(QDepth - 2);
  assign out_vld_o  = count_r != '0;
  assign out_res_o  = mem[rd_ptr_r];
  assign pop        = out_vld_o & out_rdy_i;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PtrW'(push_i.n);
    rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
    count_nxt  = count_r + (PtrW+1)'(push_i.n) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_i.n != 2'd0) begin
      mem[wr_ptr_r] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem[wr_ptr_r + PtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
